### rtl/core/pfla_pkg.sv
// Shared types and codes for the partitioned free-list allocator
`timescale 1ns / 1ps

package pfla_pkg;

   // handle and count widths fixed by the stream fields
   localparam int HANDLE_W = 6;
   localparam int FREE_W   = 7;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int TID_W    = 8;

   typedef logic [HANDLE_W-1:0] handle_type;
   typedef logic [FREE_W-1:0]   free_type;
   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [TID_W-1:0]    tid_type;

   // operation codes
   localparam op_type OP_ACQUIRE     = 2'd0;
   localparam op_type OP_RELEASE     = 2'd1;
   localparam op_type OP_RELEASE_ANY = 2'd2;

   // status codes
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_EXHAUSTED = 2'd1;
   localparam status_type ST_FULL      = 2'd2;
   localparam status_type ST_NULL      = 2'd3;

   localparam free_type FREE_MAX = 7'd127;

endpackage

### rtl/core/pfla_stack_mem.sv
// Handle stack storage with a power-up sweep that loads every slot
`timescale 1ns / 1ps

module pfla_stack_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   output logic                 busy,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  pfla_pkg::handle_type wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output pfla_pkg::handle_type rd_data
);
   import pfla_pkg::*;

   handle_type mem [DEPTH];

   logic          busy_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [AW-1:0] clr_addr_in;
   logic          busy_in;
   handle_type    rd_data_ff;

   // sweep counter: slot a starts out holding handle a
   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         if (clr_addr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // single write port, sweep has priority
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         mem[clr_addr_ff] <= HANDLE_W'(clr_addr_ff);
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign busy    = busy_ff;
   assign rd_data = rd_data_ff;

endmodule

### rtl/core/partitioned_free_list_allocator_core.sv
// Partitioned free-list handle allocator, top level
`timescale 1ns / 1ps

// Hands out and takes back buffer handles kept in NUM_PARTS LIFO stacks of
// PER_PART slots each. One request is accepted per clock cycle while req_tready
// is high; its response passes through the request register, then the stack
// memory read and the response register. Acquire pops from partition
// caller_id mod NUM_PARTS, else from the lowest non-empty other partition;
// release pushes to the caller's partition, release to partition zero
// pushes to partition 0.
// After reset the stack memory is loaded by a sweep over all NUM_PARTS*PER_PART
// slots, one slot per cycle, during which req_tready stays low.
module partitioned_free_list_allocator_core #(
   parameter int NUM_PARTS = 4,
   parameter int PER_PART  = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // caller_id[7:0], handle[13:8], zero pad
   input  logic [2:0]  req_tuser,   // op[1:0], handle_present[2]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // granted_handle[5:0], local_free[12:6],
                                    // total_free[19:13], zero pad
   output logic [1:0]  rsp_tuser    // status[1:0]
);
   import pfla_pkg::*;

   localparam int DEPTH = NUM_PARTS * PER_PART;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW    = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
   localparam int CW    = $clog2(PER_PART + 1);
   localparam int TW    = $clog2(DEPTH + 1);

   // request stage
   logic          s1_valid_ff;
   op_type        s1_op_ff;
   logic [PW-1:0] s1_part_ff;
   handle_type    s1_handle_ff;
   logic          s1_present_ff;
   logic [PW-1:0] req_part;

   // partition state
   logic [CW-1:0] counts_ff [NUM_PARTS];
   logic [CW-1:0] counts_in [NUM_PARTS];
   logic [TW-1:0] total_ff;
   logic [TW-1:0] total_in;

   // response stage
   logic       out_valid_ff;
   status_type out_status_ff;
   free_type   out_local_ff;
   free_type   out_total_ff;
   logic       out_grant_ff;
   status_type status;
   free_type   local_sat;
   free_type   total_sat;

   // control
   logic          advance;
   logic          fire;
   logic          clr_busy;
   logic          do_pop;
   logic          do_push;
   logic [PW-1:0] src;
   logic [PW-1:0] dst;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   handle_type    rd_data;

   // caller id reduced modulo the partition count by conditional subtraction
   always_comb begin
      logic [TID_W-1:0] r;
      r = req_tdata[7:0];
      for (int k = TID_W - 1; k >= 0; k--) begin
         if (int'(r) >= (NUM_PARTS << k)) begin
            r = r - TID_W'(NUM_PARTS << k);
         end
      end
      req_part = PW'(r);
   end

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !clr_busy && (!s1_valid_ff || advance);
   assign fire       = s1_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_op_ff      <= req_tuser[1:0];
         s1_part_ff    <= req_part;
         s1_handle_ff  <= req_tdata[13:8];
         s1_present_ff <= req_tuser[2];
      end
   end

   // pop/push decision, steal scan and count update
   always_comb begin
      logic       found;
      logic [PW-1:0] pick;
      found    = 1'b0;
      pick     = '0;
      do_pop   = 1'b0;
      do_push  = 1'b0;
      src      = s1_part_ff;
      dst      = '0;
      status   = ST_OK;
      total_in = total_ff;
      for (int p = 0; p < NUM_PARTS; p++) begin
         if (!found && PW'(p) != s1_part_ff && counts_ff[p] != '0) begin
            found = 1'b1;
            pick  = PW'(p);
         end
      end
      unique case (s1_op_ff) inside
         OP_ACQUIRE: begin
            if (counts_ff[s1_part_ff] != '0) begin
               do_pop = 1'b1;
            end else if (found) begin
               do_pop = 1'b1;
               src    = pick;
            end else begin
               status = ST_EXHAUSTED;
            end
         end
         OP_RELEASE, OP_RELEASE_ANY: begin
            dst = (s1_op_ff == OP_RELEASE) ? s1_part_ff : '0;
            if (!s1_present_ff) begin
               status = ST_NULL;
            end else if (int'(counts_ff[dst]) >= PER_PART) begin
               status = ST_FULL;
            end else begin
               do_push = 1'b1;
            end
         end
         default: begin
            status = ST_NULL;
         end
      endcase
      for (int p = 0; p < NUM_PARTS; p++) begin
         counts_in[p] = counts_ff[p];
         if (fire && do_pop && PW'(p) == src) begin
            counts_in[p] = counts_ff[p] - CW'(1);
         end
         if (fire && do_push && PW'(p) == dst) begin
            counts_in[p] = counts_ff[p] + CW'(1);
         end
      end
      if (fire && do_pop) begin
         total_in = total_ff - TW'(1);
      end else if (fire && do_push) begin
         total_in = total_ff + TW'(1);
      end
   end

   assign rd_addr = AW'(int'(src) * PER_PART + int'(counts_ff[src]) - 1);
   assign wr_addr = AW'(int'(dst) * PER_PART + int'(counts_ff[dst]));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PARTS; p++) begin
            counts_ff[p] <= CW'(PER_PART);
         end
         total_ff <= TW'(DEPTH);
      end else begin
         counts_ff <= counts_in;
         total_ff  <= total_in;
      end
   end

   // free counts after the step, saturated to the field width
   assign local_sat = (int'(counts_in[s1_part_ff]) > int'(FREE_MAX)) ?
                      FREE_MAX : FREE_W'(counts_in[s1_part_ff]);
   assign total_sat = (int'(total_in) > int'(FREE_MAX)) ? FREE_MAX : FREE_W'(total_in);

   // stack storage
   pfla_stack_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_stack_mem (
      .clock   (clock),
      .reset   (reset),
      .busy    (clr_busy),
      .wr_en   (fire && do_push),
      .wr_addr (wr_addr),
      .wr_data (s1_handle_ff),
      .rd_en   (fire && do_pop),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_status_ff <= status;
         out_local_ff  <= local_sat;
         out_total_ff  <= total_sat;
         out_grant_ff  <= do_pop;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_total_ff, out_local_ff,
                        (out_grant_ff ? rd_data : handle_type'(0))};
   assign rsp_tuser  = out_status_ff;

endmodule
